[rtl/dtpdm_pkg.sv]
// Package with widths, codes, stage structs and arithmetic helpers of the thrust mixer.
`default_nettype none

package dtpdm_pkg;

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int HEADING_W = 14;
  localparam int FRONT_W   = 12;
  localparam int CMD_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int THRUST_W  = 7;
  localparam int CFG_IDX_W = 2;

  // Stream packing.
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // Internal widths.
  localparam int OPA_W  = 15;
  localparam int OPB_W  = 17;
  localparam int PROD_W = 34;
  localparam int ACC_W  = 40;

  // Limits and thresholds (angles and distances in 1/16 units).
  localparam int LIN_LIM    = 180;
  localparam int ANG_LIM    = 150;
  localparam int THRUST_LIM = 50;
  localparam int DEADBAND   = 16;
  localparam int DOCK_DIST  = 128;
  localparam int GAIN_PROP_RESET = 256;

  // Fraction bits dropped by each control law.
  localparam int HEAD_SHIFT = 12;
  localparam int VEL_SHIFT  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 2'd0,
    MODE_OFF_ALT  = 2'd1,
    MODE_HEADING  = 2'd2,
    MODE_VELOCITY = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV     = 2'd2;

  typedef struct packed {
    logic signed [OPA_W-1:0] opa_r;
    logic signed [OPA_W-1:0] opa_l;
    logic signed [OPB_W-1:0] opb_r;
    logic signed [OPB_W-1:0] opb_l;
    logic signed [OPB_W-1:0] opc;
    logic                    heading_law;
    logic                    docked;
  } op_stage_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_a_r;
    logic signed [PROD_W-1:0] prod_a_l;
    logic signed [PROD_W-1:0] prod_b_r;
    logic signed [PROD_W-1:0] prod_b_l;
    logic signed [PROD_W-1:0] prod_c;
    logic                     heading_law;
    logic                     docked;
  } prod_stage_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]  acc_r;
    logic signed [ACC_W-1:0]  acc_l;
    logic signed [PROD_W-1:0] prod_c;
    logic                     heading_law;
    logic                     docked;
  } acc_stage_t;

  // Divide by 2^12 (heading law) or 2^8 (velocity law), rounding toward zero.
  function automatic logic signed [ACC_W-1:0] trunc_shift(
    input logic signed [ACC_W-1:0] x,
    input logic                    heading_law
  );
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] xb;
    bias = heading_law ? ACC_W'((1 << HEAD_SHIFT) - 1) : ACC_W'((1 << VEL_SHIFT) - 1);
    xb   = (x < 0) ? (x + bias) : x;
    return heading_law ? (xb >>> HEAD_SHIFT) : (xb >>> VEL_SHIFT);
  endfunction

  // Scale an integer back up by the fraction bits of the selected law.
  function automatic logic signed [ACC_W-1:0] scale_up(
    input logic signed [ACC_W-1:0] x,
    input logic                    heading_law
  );
    return heading_law ? (x <<< HEAD_SHIFT) : (x <<< VEL_SHIFT);
  endfunction

  function automatic logic signed [THRUST_W-1:0] clamp_thrust(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [THRUST_W-1:0] y;
    if (x > ACC_W'(THRUST_LIM)) begin
      y = THRUST_W'(THRUST_LIM);
    end else if (x < ACC_W'(-THRUST_LIM)) begin
      y = THRUST_W'(-THRUST_LIM);
    end else begin
      y = x[THRUST_W-1:0];
    end
    return y;
  endfunction

  function automatic logic signed [CMD_W-1:0] clamp_cmd(
    input logic signed [CMD_W-1:0] x,
    input int                      lim
  );
    logic signed [CMD_W-1:0] y;
    if (x > CMD_W'(lim)) begin
      y = CMD_W'(lim);
    end else if (x < CMD_W'(-lim)) begin
      y = CMD_W'(-lim);
    end else begin
      y = x;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

[rtl/differential_thrust_pd_mixer.sv]
// Top level of the differential-thrust PD mixer: operand, product, accumulate and output stages.
`default_nettype none

// One control tick per input beat gives one thrust pair per output beat. Mode 2 holds the
// configured target heading with a PD law: errors under one degree give zero thrust, and when
// the front range reads between 0 and 8 units and the signed error is at most one degree the
// boat is docked, thrust is zero and the docked flag is set. Mode 3 clamps the linear and
// angular commands to plus or minus 180 and 150 and mixes them with a PD law against the
// previous tick's commands. Modes 0 and 1 give zero thrust. Both thrusts are clamped to plus or
// minus 50 and the left one is negated. The block is a four-stage pipeline (operand register,
// product register, accumulate register, output register) and takes one beat in every cycle
// while s_axis_tready is high. A stalled output only stops the stages that are full, so
// input beats keep flowing into empty stages behind it. The configuration port is always
// ready and must only be written while the pipeline is empty.
module differential_thrust_pd_mixer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input stream.
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // tdata fields from bit 0 up: heading[13:0], front_distance[25:14], linear_cmd[41:26],
  // angular_cmd[57:42], zero fill [63:58].
  input  wire logic [dtpdm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser fields from bit 0 up: mode[1:0].
  input  wire logic [dtpdm_pkg::MODE_W-1:0]       s_axis_tuser,
  // Output stream.
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata fields from bit 0 up: thrust_right[6:0], thrust_left[13:7], zero fill [15:14].
  output      logic [dtpdm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser fields from bit 0 up: docked[0].
  output      logic                               m_axis_tuser,
  // Configuration write channel.
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [dtpdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtpdm_pkg::GAIN_W-1:0]       cfg_data
);
  import dtpdm_pkg::*;

  // Configuration registers.
  logic signed [HEADING_W-1:0] target_heading;
  logic        [GAIN_W-1:0]    gain_prop;
  logic        [GAIN_W-1:0]    gain_deriv;

  // Previous-tick state, updated in beat order as each input beat is taken.
  logic signed [HEADING_W-1:0] prev_heading;
  logic signed [CMD_W-1:0]     prev_linear;
  logic signed [CMD_W-1:0]     prev_angular;

  // Pipeline stages.
  logic        v0, v1, v2, vo;
  op_stage_t   s0, s0_next;
  prod_stage_t s1, s1_next;
  acc_stage_t  s2, s2_next;
  logic signed [THRUST_W-1:0] out_right, out_right_next;
  logic signed [THRUST_W-1:0] out_left, out_left_next;
  logic                       out_docked;

  logic free0, free1, free2, free3;
  logic in_beat;

  // A stage may load when it is empty or its content moves on in the same cycle.
  assign free3 = !vo || m_axis_tready;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;
  assign free0 = !v0 || free1;

  assign s_axis_tready = free0;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration writes. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      gain_prop      <= GAIN_W'(GAIN_PROP_RESET);
      gain_deriv     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_HEADING: target_heading <= cfg_data[HEADING_W-1:0];
        CFG_GAIN_PROP:      gain_prop      <= cfg_data;
        CFG_GAIN_DERIV:     gain_deriv     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand stage: unpack, clamp, form the error and differences and pick the law.
  logic signed [HEADING_W-1:0] in_heading;
  logic signed [FRONT_W-1:0]   in_front;
  logic signed [CMD_W-1:0]     in_linear;
  logic signed [CMD_W-1:0]     in_angular;
  mode_t                       in_mode;
  logic signed [CMD_W-1:0]     lin_eff;
  logic signed [CMD_W-1:0]     ang_eff;
  logic signed [OPA_W-1:0]     err;
  logic signed [OPA_W-1:0]     d_head;
  logic signed [OPB_W-1:0]     d_lin;
  logic signed [OPB_W-1:0]     d_ang;
  logic                        outside_deadband;
  logic                        dock_hit;

  assign in_heading = s_axis_tdata[13:0];
  assign in_front   = s_axis_tdata[25:14];
  assign in_linear  = s_axis_tdata[41:26];
  assign in_angular = s_axis_tdata[57:42];
  assign in_mode    = mode_t'(s_axis_tuser);

  always_comb begin
    // Commands are clamped only in velocity mode; the state keeps what the law used.
    if (in_mode == MODE_VELOCITY) begin
      lin_eff = clamp_cmd(in_linear, LIN_LIM);
      ang_eff = clamp_cmd(in_angular, ANG_LIM);
    end else begin
      lin_eff = in_linear;
      ang_eff = in_angular;
    end

    err    = OPA_W'(target_heading) - OPA_W'(in_heading);
    d_head = OPA_W'(in_heading) - OPA_W'(prev_heading);
    d_lin  = OPB_W'(lin_eff) - OPB_W'(prev_linear);
    d_ang  = OPB_W'(ang_eff) - OPB_W'(prev_angular);

    outside_deadband = (err >= OPA_W'(DEADBAND)) || (err <= OPA_W'(-DEADBAND));
    dock_hit = (in_front >= 0) && (in_front <= FRONT_W'(DOCK_DIST))
            && (err <= OPA_W'(DEADBAND));

    // Zero operands give zero thrust through the rest of the pipeline.
    s0_next = '0;
    case (in_mode)
      MODE_HEADING: begin
        s0_next.heading_law = 1'b1;
        if (dock_hit) begin
          s0_next.docked = 1'b1;
        end else if (outside_deadband) begin
          s0_next.opa_r = -err;
          s0_next.opa_l = err;
          s0_next.opb_r = OPB_W'(d_head);
          s0_next.opb_l = -OPB_W'(d_head);
        end
      end
      MODE_VELOCITY: begin
        s0_next.opa_r = OPA_W'(lin_eff) + OPA_W'(ang_eff);
        s0_next.opa_l = OPA_W'(lin_eff) - OPA_W'(ang_eff);
        s0_next.opb_r = d_lin;
        s0_next.opb_l = d_lin;
        s0_next.opc   = -d_ang;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_heading <= '0;
      prev_linear  <= '0;
      prev_angular <= '0;
    end else if (in_beat) begin
      prev_heading <= in_heading;
      prev_linear  <= lin_eff;
      prev_angular <= ang_eff;
    end
  end

  // Product stage: five parallel gain multiplications.
  logic signed [GAIN_W:0] kp_s;
  logic signed [GAIN_W:0] kd_s;

  assign kp_s = {1'b0, gain_prop};
  assign kd_s = {1'b0, gain_deriv};

  always_comb begin
    s1_next.prod_a_r    = PROD_W'(s0.opa_r * kp_s);
    s1_next.prod_a_l    = PROD_W'(s0.opa_l * kp_s);
    s1_next.prod_b_r    = PROD_W'(s0.opb_r * kd_s);
    s1_next.prod_b_l    = PROD_W'(s0.opb_l * kd_s);
    s1_next.prod_c      = PROD_W'(s0.opc * kd_s);
    s1_next.heading_law = s0.heading_law;
    s1_next.docked      = s0.docked;
  end

  // Accumulate stage: the first two truncating steps of each thrust.
  logic signed [ACC_W-1:0] first_r;
  logic signed [ACC_W-1:0] first_l;

  always_comb begin
    first_r = trunc_shift(ACC_W'(s1.prod_a_r), s1.heading_law);
    first_l = trunc_shift(ACC_W'(s1.prod_a_l), s1.heading_law);
    s2_next.acc_r = trunc_shift(scale_up(first_r, s1.heading_law) + ACC_W'(s1.prod_b_r),
                                s1.heading_law);
    s2_next.acc_l = trunc_shift(scale_up(first_l, s1.heading_law) + ACC_W'(s1.prod_b_l),
                                s1.heading_law);
    s2_next.prod_c      = s1.prod_c;
    s2_next.heading_law = s1.heading_law;
    s2_next.docked      = s1.docked;
  end

  // Output stage: the velocity law's angular-rate term, then clamp and negate left.
  logic signed [ACC_W-1:0] final_r;
  logic signed [ACC_W-1:0] final_l;

  always_comb begin
    if (s2.heading_law) begin
      final_r = s2.acc_r;
      final_l = s2.acc_l;
    end else begin
      final_r = trunc_shift(scale_up(s2.acc_r, 1'b0) + ACC_W'(s2.prod_c), 1'b0);
      final_l = trunc_shift(scale_up(s2.acc_l, 1'b0) + ACC_W'(s2.prod_c), 1'b0);
    end
    out_right_next = clamp_thrust(final_r);
    out_left_next  = -clamp_thrust(final_l);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (free0) v0 <= s_axis_tvalid;
      if (free1) v1 <= v0;
      if (free2) v2 <= v1;
      if (free3) vo <= v2;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (free0) s0 <= s0_next;
    if (free1) s1 <= s1_next;
    if (free2) s2 <= s2_next;
    if (free3) begin
      out_right  <= out_right_next;
      out_left   <= out_left_next;
      out_docked <= s2.docked;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {2'b00, out_left, out_right};
  assign m_axis_tuser  = out_docked;

  // A docked result always carries zero thrust.
  a_docked_zero: assert property (@(posedge clk) disable iff (rst)
    (vo && out_docked) |-> (out_right == 0 && out_left == 0))
    else $error("docked result with nonzero thrust");

  // Thrusts stay within the clamp.
  a_thrust_range: assert property (@(posedge clk) disable iff (rst)
    vo |-> (out_right <= THRUST_W'(THRUST_LIM) && out_right >= THRUST_W'(-THRUST_LIM)
         && out_left <= THRUST_W'(THRUST_LIM) && out_left >= THRUST_W'(-THRUST_LIM)))
    else $error("thrust outside clamp");

  // A taken input beat always lands in the operand stage.
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> v0)
    else $error("input beat lost");

  // The accumulate stage holds its content while the output is blocked.
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !free3) |=> (v2 && $stable(s2)))
    else $error("accumulate stage changed under stall");

  // Only the heading law can report docking.
  a_dock_law: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.docked) |-> s2.heading_law)
    else $error("docked flag outside heading law");

endmodule

`default_nettype wire
